### hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; take in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define B64D_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication on every clock edge outside reset.
`define B64D_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/b64d_pkg.sv
// Shared types and constants of the Base64 stream decoder.
// Depends on nothing; used by the front end, job queue, back end and top level.
package b64d_pkg;

    localparam int BYTE_W        = 8;
    localparam int SEXTET_W      = 6;
    localparam int GATHER_W      = 18;
    localparam int JOB_DEPTH_DEF = 2;

    // One decoded job: up to three bytes, first byte in the high bits.
    typedef struct packed {
        logic [3*BYTE_W-1:0] bytes;
        logic [1:0]          count;
        logic                last;
    } job_t;

endpackage

### hdl/b64d_job_fifo.sv
// Short queue of decoded jobs between the front end and the back end.
// Depends on b64d_pkg for job_t.
module b64d_job_fifo
    import b64d_pkg::*;
#(
    parameter int DEPTH = JOB_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### hdl/b64d_front.sv
// Front end: classifies each character, gathers sextets and forms byte jobs.
// Depends on b64d_pkg for job_t and field widths.
module b64d_front
    import b64d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [BYTE_W-1:0] symbol,
    input  logic              end_of_message,
    output logic              job_push,
    output job_t              job
);

    localparam logic [BYTE_W-1:0] CH_UP_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z = 8'h5a;
    localparam logic [BYTE_W-1:0] CH_LO_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_Z = 8'h7a;
    localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2b;
    localparam logic [BYTE_W-1:0] CH_SLSH = 8'h2f;

    logic [1:0]          held_reg, held_next;
    logic [GATHER_W-1:0] gather_reg, gather_next;
    logic                halted_reg, halted_next;
    logic                sx_ok;
    logic [SEXTET_W-1:0] sx_val;
    logic [1:0]          n_bytes;

    // Map an ASCII code to its six-bit value; '=' and anything else is invalid.
    always_comb
    begin
        sx_ok  = 1'b1;
        sx_val = '0;
        if (symbol >= CH_UP_A && symbol <= CH_UP_Z)
        begin
            sx_val = SEXTET_W'(symbol - CH_UP_A);
        end
        else if (symbol >= CH_LO_A && symbol <= CH_LO_Z)
        begin
            sx_val = SEXTET_W'(symbol - CH_LO_A + 8'd26);
        end
        else if (symbol >= CH_0 && symbol <= CH_9)
        begin
            sx_val = SEXTET_W'(symbol - CH_0 + 8'd52);
        end
        else if (symbol == CH_PLUS)
        begin
            sx_val = SEXTET_W'(62);
        end
        else if (symbol == CH_SLSH)
        begin
            sx_val = SEXTET_W'(63);
        end
        else
        begin
            sx_ok = 1'b0;
        end
    end

    always_comb
    begin
        held_next   = held_reg;
        gather_next = gather_reg;
        halted_next = halted_reg;
        job         = '0;
        n_bytes     = 2'd0;

        if (!halted_reg)
        begin
            if (!sx_ok)
            begin
                halted_next = 1'b1;
            end
            else if (held_reg == 2'd3)
            begin
                job.bytes   = {gather_reg, sx_val};
                n_bytes     = 2'd3;
                held_next   = 2'd0;
                gather_next = '0;
            end
            else
            begin
                gather_next = {gather_reg[GATHER_W-SEXTET_W-1:0], sx_val};
                held_next   = held_reg + 2'd1;
            end
        end

        // Flush a partial group and return to the reset state.
        if (end_of_message)
        begin
            if (held_next == 2'd2)
            begin
                job.bytes = {gather_next[11:4], 16'h0000};
                n_bytes   = 2'd1;
            end
            else if (held_next == 2'd3)
            begin
                job.bytes = {gather_next[17:10], gather_next[9:2], 8'h00};
                n_bytes   = 2'd2;
            end
            job.last    = 1'b1;
            held_next   = 2'd0;
            gather_next = '0;
            halted_next = 1'b0;
        end

        job.count = n_bytes;
    end

    assign job_push = take && ((n_bytes != 2'd0) || end_of_message);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            gather_reg <= '0;
            halted_reg <= 1'b0;
        end
        else if (take)
        begin
            held_reg   <= held_next;
            gather_reg <= gather_next;
            halted_reg <= halted_next;
        end
    end

endmodule

### hdl/b64d_back.sv
// Back end: takes jobs from the queue and presents them one byte per word.
// Depends on b64d_pkg for job_t and field widths.
module b64d_back
    import b64d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  job_t              q_job,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [BYTE_W-1:0] data_byte,
    output logic              byte_valid,
    output logic              last
);

    logic       busy_reg;
    job_t       job_reg;
    logic [1:0] idx_reg;
    logic [1:0] final_idx;
    logic       at_final;
    logic       take;

    assign final_idx = (job_reg.count == 2'd0) ? 2'd0 : job_reg.count - 2'd1;
    assign at_final  = (idx_reg == final_idx);
    assign take      = pop && busy_reg;
    assign q_pop     = !q_empty && (!busy_reg || (take && at_final));

    assign empty      = !busy_reg;
    assign byte_valid = (job_reg.count != 2'd0);
    assign last       = job_reg.last && at_final;

    always_comb
    begin
        case (idx_reg)
            2'd0:    data_byte = job_reg.bytes[23:16];
            2'd1:    data_byte = job_reg.bytes[15:8];
            default: data_byte = job_reg.bytes[7:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (q_pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            if (at_final)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
    end

endmodule

### hdl/base64_stream_decoder_unit.sv
// Top level of the Base64 stream decoder: front end, job queue, back end.
// Depends on b64d_pkg, b64d_front, b64d_job_fifo and b64d_back.
//
//   port group   direction  handshake        payload
//   input        in         push / full      symbol, end_of_message
//   result       out        empty / pop      data_byte, byte_valid, last
//
// One character enters per cycle while full is low; the front end updates
// its gather state in that cycle and queues the job the character causes.
// The back end presents one word per cycle while pop is high, so a completed
// group gives three result words; the job queue (JOB_DEPTH entries) absorbs
// that burst, though short messages right behind a completed group can stall
// the input briefly. The first word of a character shows after its job has
// been queued and then loaded into the back end. Reset clears all control
// state asynchronously; full rises only when the job queue is full.
module base64_stream_decoder_unit
    import b64d_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] symbol,
    input  logic              end_of_message,
    input  logic              pop,
    output logic              empty,
    output logic [BYTE_W-1:0] data_byte,
    output logic              byte_valid,
    output logic              last
);

    logic take;
    logic job_push;
    job_t job_in;
    logic q_full;
    logic q_empty;
    logic q_pop;
    job_t q_job;

    assign full = q_full;
    assign take = push && !q_full;

    b64d_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .symbol         (symbol),
        .end_of_message (end_of_message),
        .job_push       (job_push),
        .job            (job_in)
    );

    b64d_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_job (q_job),
        .empty  (q_empty)
    );

    b64d_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_job      (q_job),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last       (last)
    );

endmodule

### hdl/b64d_checker.sv
// Port-level checker for the Base64 stream decoder, bound to the top level.
// Depends on assert_macros.svh and b64d_pkg.
`include "assert_macros.svh"

module b64d_checker
    import b64d_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              end_of_message,
    input logic              pop,
    input logic              empty,
    input logic [BYTE_W-1:0] data_byte,
    input logic              byte_valid,
    input logic              last
);

    // A waiting word holds until it is taken.
    `B64D_ASSERT_NXT(a_hold_word, clk, rst_n, !empty && !pop, !empty && $stable(data_byte) && $stable(byte_valid) && $stable(last), "result word changed while waiting")

    // A word without a byte carries zero data.
    `B64D_ASSERT_IMP(a_empty_byte_zero, clk, rst_n, !empty && !byte_valid, data_byte == '0, "no-byte word has nonzero data")

    // A word without a byte only closes a message.
    `B64D_ASSERT_IMP(a_empty_byte_last, clk, rst_n, !empty && !byte_valid, last, "no-byte word is not marked last")

    // An accepted end mark is checked to have a word waiting after its job is
    // queued and then loaded into the back end.
    `B64D_ASSERT_NXT(a_eom_gives_word, clk, rst_n, push && !full && end_of_message, ##1 !empty, "no word two cycles after end of message")

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (.*);

### tb/sv/base64_stream_decoder_unit_tb.sv
// Self-checking testbench of the Base64 stream decoder top level.
// Depends on b64d_pkg and base64_stream_decoder_unit; predicts every result
// word from its own model of the decoder and checks the words in order.
module base64_stream_decoder_unit_tb;
    import b64d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 150;
    localparam int TAIL_CYCLES = 8;

    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_PAD     = 8'h3D;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
    } dec_word_t;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              push           = 1'b0;
    logic [BYTE_W-1:0] symbol         = '0;
    logic              end_of_message = 1'b0;
    logic              pop            = 1'b0;
    logic              full;
    logic              empty;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_valid;
    logic              last;

    // Decoder state as predicted
    logic [1:0]          held_count = '0;
    logic [GATHER_W-1:0] gather     = '0;
    logic                stopped    = 1'b0;

    dec_word_t decoded_q[$];

    int  errors        = 0;
    int  words_sent    = 0;
    int  words_checked = 0;
    int  messages_done = 0;
    int  hold_request  = 0;
    bit  no_gaps       = 1'b0;

    base64_stream_decoder_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .symbol         (symbol),
        .end_of_message (end_of_message),
        .pop            (pop),
        .empty          (empty),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .last           (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Bit 6 set means pad or invalid character
    function automatic logic [6:0] sextet_value(input logic [BYTE_W-1:0] ch);
        logic [BYTE_W-1:0] d;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
        begin
            d = ch - CH_UPPER_A;
            return {1'b0, d[5:0]};
        end
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
        begin
            d = ch - CH_LOWER_A + 8'd26;
            return {1'b0, d[5:0]};
        end
        if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
        begin
            d = ch - CH_DIGIT_0 + 8'd52;
            return {1'b0, d[5:0]};
        end
        if (ch == CH_PLUS)
            return 7'd62;
        if (ch == CH_SLASH)
            return 7'd63;
        return 7'h40;
    endfunction

    function automatic logic [BYTE_W-1:0] b64_char(input logic [5:0] idx);
        if (idx < 6'd26)
            return CH_UPPER_A + BYTE_W'(idx);
        if (idx < 6'd52)
            return CH_LOWER_A + BYTE_W'(idx - 6'd26);
        if (idx < 6'd62)
            return CH_DIGIT_0 + BYTE_W'(idx - 6'd52);
        if (idx == 6'd62)
            return CH_PLUS;
        return CH_SLASH;
    endfunction

    function automatic int idle_gap();
        int roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic predict_decode(input logic [BYTE_W-1:0] ch, input logic eom);
        logic [6:0]  code;
        logic [23:0] grp;
        dec_word_t   outs[3];
        int          n_out;
        n_out = 0;
        if (!stopped)
        begin
            code = sextet_value(ch);
            if (code[6])
                stopped = 1'b1;
            else if (held_count == 2'd3)
            begin
                grp = {gather, code[5:0]};
                outs[0] = '{grp[23:16], 1'b1, 1'b0};
                outs[1] = '{grp[15:8], 1'b1, 1'b0};
                outs[2] = '{grp[7:0], 1'b1, 1'b0};
                n_out = 3;
                held_count = '0;
                gather = '0;
            end
            else
            begin
                gather = {gather[11:0], code[5:0]};
                held_count = held_count + 2'd1;
            end
        end
        if (eom)
        begin
            if (held_count == 2'd2)
            begin
                outs[n_out] = '{gather[11:4], 1'b1, 1'b0};
                n_out++;
            end
            else if (held_count == 2'd3)
            begin
                outs[n_out] = '{gather[17:10], 1'b1, 1'b0};
                outs[n_out + 1] = '{gather[9:2], 1'b1, 1'b0};
                n_out += 2;
            end
            if (n_out == 0)
            begin
                outs[0] = '{'0, 1'b0, 1'b1};
                n_out = 1;
            end
            else
                outs[n_out - 1].last = 1'b1;
            held_count = '0;
            gather = '0;
            stopped = 1'b0;
            messages_done++;
        end
        for (int i = 0; i < n_out; i++)
            decoded_q.push_back(outs[i]);
    endtask

    // Offer one character; push stays high on return so the next word can follow
    task automatic send_word(input logic [BYTE_W-1:0] ch, input logic eom);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        symbol <= ch;
        end_of_message <= eom;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_decode(ch, eom);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], i == s.len() - 1);
    endtask

    task automatic send_random_message(input int len, input bit noisy);
        logic [BYTE_W-1:0] ch;
        for (int i = 0; i < len; i++)
        begin
            ch = b64_char(6'($urandom_range(0, 63)));
            if (noisy && $urandom_range(0, 5) == 0)
                ch = BYTE_W'($urandom_range(0, 255));
            send_word(ch, i == len - 1);
        end
    endtask

    // Whole groups, then an optional two- or three-symbol tail padded to four
    task automatic send_padded_message();
        logic [BYTE_W-1:0] text[$];
        int groups;
        int tail;
        groups = $urandom_range(0, 2);
        tail = $urandom_range(0, 2);
        if (tail > 0)
            tail = tail + 1;
        if (groups == 0 && tail == 0)
            tail = 2;
        repeat (groups * 4 + tail) text.push_back(b64_char(6'($urandom_range(0, 63))));
        if (tail > 0)
            repeat (4 - tail) text.push_back(CH_PAD);
        foreach (text[i])
            send_word(text[i], i == text.size() - 1);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_text("AZaz09+/");
        send_text("T");
        send_text("TW");
        send_text("TWF");
        send_text("TW==");
        send_text("TW-x");
        // invalid code stops the message; later valid characters are dropped
        send_word("Q", 1'b0);
        send_word(8'hFF, 1'b0);
        send_word("A", 1'b1);
        send_word(8'h00, 1'b1);
    endtask

    task automatic test_random_messages();
        int start;
        int roll;
        start = words_sent;
        while (words_sent - start < 30)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                send_padded_message();
            else
                send_random_message($urandom_range(1, 12), roll >= 85);
        end
    endtask

    // Stall the output long enough for the job queue to fill and raise full
    task automatic test_backpressure();
        no_gaps = 1'b1;
        hold_request = LONG_HOLD;
        for (int i = 0; i < 16; i++)
            send_word(b64_char(6'($urandom_range(0, 63))), i == 15);
        no_gaps = 1'b0;
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        repeat (4) send_padded_message();
        no_gaps = 1'b0;
    endtask

    initial
    begin : result_checker
        dec_word_t got;
        dec_word_t want;
        int gap_left;
        int hold_left;
        gap_left = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got = '{data_byte, byte_valid, last};
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected word: byte %h valid %b last %b",
                             $time, got.data, got.valid, got.last);
                    errors++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (got !== want)
                    begin
                        $display({"%0t: mismatch: expected byte %h valid %b last %b, ",
                                  "got byte %h valid %b last %b"},
                                 $time, want.data, want.valid, want.last,
                                 got.data, got.valid, got.last);
                        errors++;
                    end
                    words_checked++;
                end
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                gap_left = idle_gap();
            end
        end
    end

    initial
    begin : stall_watch
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("base64_stream_decoder_unit test failed");
        $finish;
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_random_messages();
        test_backpressure();
        wait_drained();
        test_back_to_back();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d characters in %0d messages, checked %0d result words,",
                 words_sent, messages_done, words_checked);
        $display("with padding, invalid stops, partial groups and a long output stall.");
        if (errors == 0)
            $display("base64_stream_decoder_unit test passed");
        else
            $display("base64_stream_decoder_unit test failed");
        $finish;
    end

endmodule
